// ----- hw/rtl/sgi_pkg.sv -----
// Shared types and constants for the segment intersection pipeline.
// No dependencies; used by all sgi modules and the top level.
package sgi_pkg;

    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int PLACE_W  = CROSS_W + DIFF_W;
    localparam int QUO_W    = COORD_W + 2;
    localparam int DIV_W    = PLACE_W + 4;
    localparam int SUM_W    = QUO_W + 2;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int IN_W     = 8 * COORD_W;
    localparam int OUT_W    = 40;
    localparam int USER_W   = 2;

    localparam logic [1:0] CASE_SHARED   = 2'd0;
    localparam logic [1:0] CASE_CROSS    = 2'd1;
    localparam logic [1:0] CASE_PARALLEL = 2'd2;

    typedef struct packed {
        logic                       valid;
        logic [1:0]                 code;
        logic                       hit;
        logic signed [COORD_W-1:0]  base_x;
        logic signed [COORD_W-1:0]  base_y;
        logic signed [COORD_W-1:0]  alt_x;
        logic signed [COORD_W-1:0]  alt_y;
    } meta_t;

endpackage

// ----- hw/rtl/sgi_front.sv -----
// Front stages: differences, cross products, numerators and the scaled offsets.
// Depends on sgi_pkg.
module sgi_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [sgi_pkg::IN_W-1:0]           in_data,
    output sgi_pkg::meta_t                     meta_out,
    output logic signed [sgi_pkg::PLACE_W-1:0] px_out,
    output logic signed [sgi_pkg::PLACE_W-1:0] py_out,
    output logic signed [sgi_pkg::CROSS_W-1:0] d_out
);
    localparam int CW = sgi_pkg::COORD_W;
    localparam int DW = sgi_pkg::DIFF_W;
    localparam int PW = sgi_pkg::PROD_W;
    localparam int XW = sgi_pkg::CROSS_W;
    localparam int LW = sgi_pkg::PLACE_W;

    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    logic signed [DW-1:0] sum_x, sum_y;
    sgi_pkg::meta_t m1_next, m1_reg, m2_reg, m3_next, m3_reg, m4_next, m4_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] dx1b_reg, dy1b_reg, dx1c_reg, dy1c_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [XW-1:0] d_next, n1_next, n2_next, d_reg, n1_reg, n2_reg;
    logic signed [XW:0]   dn, n1n, n2n;
    logic signed [LW-1:0] px_reg, py_reg;
    logic signed [XW-1:0] d4_reg;

    assign x1 = in_data[0*CW +: CW];
    assign y1 = in_data[1*CW +: CW];
    assign x2 = in_data[2*CW +: CW];
    assign y2 = in_data[3*CW +: CW];
    assign x3 = in_data[4*CW +: CW];
    assign y3 = in_data[5*CW +: CW];
    assign x4 = in_data[6*CW +: CW];
    assign y4 = in_data[7*CW +: CW];

    assign sum_x = DW'(x2) + DW'(x3);
    assign sum_y = DW'(y2) + DW'(y3);

    always_comb begin
        m1_next        = '0;
        m1_next.valid  = in_valid;
        m1_next.base_x = x1;
        m1_next.base_y = y1;
        if (x2 == x3 && y2 == y3) begin
            m1_next.code  = sgi_pkg::CASE_SHARED;
            m1_next.hit   = 1'b1;
            m1_next.alt_x = x2;
            m1_next.alt_y = y2;
        end else begin
            m1_next.code  = sgi_pkg::CASE_CROSS;
            m1_next.hit   = 1'b0;
            m1_next.alt_x = sum_x[DW-1:1];
            m1_next.alt_y = sum_y[DW-1:1];
        end
    end

    assign d_next  = XW'(pa_reg) - XW'(pb_reg);
    assign n1_next = XW'(pc_reg) - XW'(pd_reg);
    assign n2_next = XW'(pe_reg) - XW'(pf_reg);

    always_comb begin
        m3_next = m2_reg;
        if (m2_reg.code != sgi_pkg::CASE_SHARED && d_next == '0) begin
            m3_next.code = sgi_pkg::CASE_PARALLEL;
        end
    end

    always_comb begin
        if (d_reg[XW-1]) begin
            dn  = -(XW+1)'(d_reg);
            n1n = -(XW+1)'(n1_reg);
            n2n = -(XW+1)'(n2_reg);
        end else begin
            dn  = (XW+1)'(d_reg);
            n1n = (XW+1)'(n1_reg);
            n2n = (XW+1)'(n2_reg);
        end
        m4_next = m3_reg;
        if (m3_reg.code == sgi_pkg::CASE_CROSS) begin
            m4_next.hit = !n1n[XW] && !n2n[XW] && (n1n <= dn) && (n2n <= dn);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_reg.valid <= 1'b0;
            m2_reg.valid <= 1'b0;
            m3_reg.valid <= 1'b0;
            m4_reg.valid <= 1'b0;
        end else if (en) begin
            m1_reg <= m1_next;
            m2_reg <= m1_reg;
            m3_reg <= m3_next;
            m4_reg <= m4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg  <= DW'(x2) - DW'(x1);
            dy1_reg  <= DW'(y2) - DW'(y1);
            dx2_reg  <= DW'(x4) - DW'(x3);
            dy2_reg  <= DW'(y4) - DW'(y3);
            ex_reg   <= DW'(x1) - DW'(x3);
            ey_reg   <= DW'(y1) - DW'(y3);
            pa_reg   <= PW'(dx1_reg) * PW'(dy2_reg);
            pb_reg   <= PW'(dx2_reg) * PW'(dy1_reg);
            pc_reg   <= PW'(ey_reg) * PW'(dx2_reg);
            pd_reg   <= PW'(ex_reg) * PW'(dy2_reg);
            pe_reg   <= PW'(ey_reg) * PW'(dx1_reg);
            pf_reg   <= PW'(ex_reg) * PW'(dy1_reg);
            dx1b_reg <= dx1_reg;
            dy1b_reg <= dy1_reg;
            d_reg    <= d_next;
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            dx1c_reg <= dx1b_reg;
            dy1c_reg <= dy1b_reg;
            px_reg   <= LW'(n1_reg) * LW'(dx1c_reg);
            py_reg   <= LW'(n1_reg) * LW'(dy1c_reg);
            d4_reg   <= d_reg;
        end
    end

    assign meta_out = m4_reg;
    assign px_out   = px_reg;
    assign py_out   = py_reg;
    assign d_out    = d4_reg;

endmodule

// ----- hw/rtl/sgi_div.sv -----
// One divider lane: rounded quotient |p|/|d| by restoring steps, one bit per stage.
// Depends on sgi_pkg.
module sgi_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [sgi_pkg::PLACE_W-1:0] p_in,
    input  logic signed [sgi_pkg::CROSS_W-1:0] d_in,
    output logic [sgi_pkg::QUO_W-1:0]          q_out,
    output logic                               neg_out,
    output logic                               ovf_out
);
    localparam int QW = sgi_pkg::QUO_W;
    localparam int VW = sgi_pkg::DIV_W;
    localparam int LW = sgi_pkg::PLACE_W;
    localparam int XW = sgi_pkg::CROSS_W;

    logic [LW-1:0] mag_p;
    logic [XW-1:0] mag_d;
    logic [VW-1:0] num, den;

    logic [VW-1:0] r_reg   [0:QW];
    logic [VW-1:0] b_reg   [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic          neg_reg [0:QW];
    logic          ovf_reg [0:QW];

    assign mag_p = p_in[LW-1] ? LW'(-p_in) : LW'(p_in);
    assign mag_d = d_in[XW-1] ? XW'(-d_in) : XW'(d_in);
    assign num   = (VW'(mag_p) << 1) + VW'(mag_d);
    assign den   = VW'(mag_d) << 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= num;
            b_reg[0]   <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= p_in[LW-1] ^ d_in[XW-1];
            ovf_reg[0] <= num >= (den << QW);
            for (int k = 0; k < QW; k++) begin
                b_reg[k+1]   <= b_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                if (r_reg[k] >= (b_reg[k] << (QW-1-k))) begin
                    r_reg[k+1] <= r_reg[k] - (b_reg[k] << (QW-1-k));
                    q_reg[k+1] <= q_reg[k] | (QW'(1) << (QW-1-k));
                end else begin
                    r_reg[k+1] <= r_reg[k];
                    q_reg[k+1] <= q_reg[k];
                end
            end
        end
    end

    assign q_out   = q_reg[QW];
    assign neg_out = neg_reg[QW];
    assign ovf_out = ovf_reg[QW];

endmodule

// ----- hw/rtl/segment_intersection.sv -----
// Segment intersection top level: front stages, two divider lanes, output register.
// One transaction per cycle while no result waits unaccepted.
// The whole pipeline advances together and halts only while a result waits unaccepted.
// Reset (aresetn low, synchronous) clears all valid bits; payload registers are not reset.
module segment_intersection (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [sgi_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cross_x, cross_y, hit, saturated, zero padding
    output logic [sgi_pkg::OUT_W-1:0]       m_tdata,
    // case_code
    output logic [sgi_pkg::USER_W-1:0]      m_tuser
);
    localparam int CW = sgi_pkg::COORD_W;
    localparam int QW = sgi_pkg::QUO_W;
    localparam int SW = sgi_pkg::SUM_W;
    localparam int NL = sgi_pkg::DIV_LAT;
    localparam logic signed [SW-1:0] V_MAX = SW'((1 << (CW-1)) - 1);
    localparam logic signed [SW-1:0] V_MIN = SW'(-(1 << (CW-1)));

    logic en;
    sgi_pkg::meta_t front_meta;
    sgi_pkg::meta_t pipe_reg [0:NL-1];
    logic signed [sgi_pkg::PLACE_W-1:0] px, py;
    logic signed [sgi_pkg::CROSS_W-1:0] d;
    logic [QW-1:0] qx, qy;
    logic negx, negy, ovfx, ovfy;
    logic signed [SW-1:0] vx, vy;
    logic signed [CW-1:0] cx, cy;
    logic satx, saty;
    sgi_pkg::meta_t last;
    logic [sgi_pkg::OUT_W-1:0] out_next, out_reg;
    logic [sgi_pkg::USER_W-1:0] user_reg;
    logic valid_reg;

    assign en       = !valid_reg || m_tready;
    assign s_tready = en;

    sgi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .meta_out (front_meta),
        .px_out   (px),
        .py_out   (py),
        .d_out    (d)
    );

    sgi_div u_div_x (
        .aclk (aclk), .en (en), .p_in (px), .d_in (d),
        .q_out (qx), .neg_out (negx), .ovf_out (ovfx)
    );

    sgi_div u_div_y (
        .aclk (aclk), .en (en), .p_in (py), .d_in (d),
        .q_out (qy), .neg_out (negy), .ovf_out (ovfy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NL; k++) begin
                pipe_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            pipe_reg[0] <= front_meta;
            for (int k = 1; k < NL; k++) begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign last = pipe_reg[NL-1];
    assign vx = negx ? SW'(last.base_x) - SW'(qx) : SW'(last.base_x) + SW'(qx);
    assign vy = negy ? SW'(last.base_y) - SW'(qy) : SW'(last.base_y) + SW'(qy);

    always_comb begin
        satx = 1'b1;
        saty = 1'b1;
        if (ovfx) begin
            cx = negx ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else if (vx > V_MAX) begin
            cx = {1'b0, {(CW-1){1'b1}}};
        end else if (vx < V_MIN) begin
            cx = {1'b1, {(CW-1){1'b0}}};
        end else begin
            cx   = vx[CW-1:0];
            satx = 1'b0;
        end
        if (ovfy) begin
            cy = negy ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else if (vy > V_MAX) begin
            cy = {1'b0, {(CW-1){1'b1}}};
        end else if (vy < V_MIN) begin
            cy = {1'b1, {(CW-1){1'b0}}};
        end else begin
            cy   = vy[CW-1:0];
            saty = 1'b0;
        end
        out_next = '0;
        if (last.code == sgi_pkg::CASE_CROSS) begin
            out_next[CW-1:0]    = cx;
            out_next[2*CW-1:CW] = cy;
            out_next[2*CW+1]    = satx || saty;
        end else begin
            out_next[CW-1:0]    = last.alt_x;
            out_next[2*CW-1:CW] = last.alt_y;
        end
        out_next[2*CW]             = last.hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg  <= out_next;
            user_reg <= last.code;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = user_reg;

    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= sgi_pkg::CASE_PARALLEL))
        else $error("illegal case code on output");

    a_shared_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == sgi_pkg::CASE_SHARED)
        |-> (m_tdata[2*CW] && !m_tdata[2*CW+1]))
        else $error("shared endpoint result must hit without saturation");

    a_parallel_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == sgi_pkg::CASE_PARALLEL)
        |-> (!m_tdata[2*CW] && !m_tdata[2*CW+1]))
        else $error("parallel result must not hit or saturate");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

endmodule
